// File: rtl/ismm_pkg.sv
// Shared types and constants for the indexed store min/max/mean unit.
`default_nettype none
package ismm_pkg;

  localparam int DEPTH     = 64;
  localparam int AW        = $clog2(DEPTH);
  localparam int CNT_W     = AW + 1;
  localparam int DATA_W    = 32;
  localparam int SUM_W     = DATA_W + AW;
  localparam int REM_W     = CNT_W - 1;
  localparam int DIV_CYC   = (SUM_W + 1) / 2;
  localparam int DIVCNT_W  = $clog2(DIV_CYC);

  localparam logic       OP_READ           = 1'b0;
  localparam logic       OP_WRITE          = 1'b1;
  localparam logic       REG_STORE_LEN     = 1'b0;
  localparam logic       REG_DEFAULT_VALUE = 1'b1;

  typedef struct packed {
    logic                     opcode;
    logic signed [7:0]        index;
    logic signed [DATA_W-1:0] value;
  } ismm_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic                     in_bounds;
    logic signed [DATA_W-1:0] minimum;
    logic signed [DATA_W-1:0] maximum;
    logic signed [DATA_W-1:0] mean;
  } ismm_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_SCAN,
    ST_LAST,
    ST_DIVGO,
    ST_DIV,
    ST_DONE
  } ismm_state_t;

endpackage
`default_nettype wire

// File: rtl/ismm_div.sv
// Iterative signed divider, two quotient bits per cycle, truncates toward zero.
`default_nettype none
module ismm_div
  import ismm_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     go,
  input  wire logic signed [SUM_W-1:0]  dividend,
  input  wire logic        [CNT_W-1:0]  divisor,
  output logic                          done,
  output logic signed [DATA_W-1:0]      quotient
);

  logic                active_r;
  logic                done_r;
  logic [DIVCNT_W-1:0] cnt_r;
  logic [SUM_W-1:0]    num_r;
  logic [REM_W-1:0]    rem_r;
  logic                neg_r;
  logic [SUM_W-1:0]    num_nxt;
  logic [REM_W-1:0]    rem_nxt;

  // two restoring steps per cycle; remainder stays below the divisor
  always_comb begin
    logic [REM_W:0]   t;
    logic [SUM_W-1:0] n;
    logic [REM_W-1:0] r;
    n = num_r;
    r = rem_r;
    for (int k = 0; k < 2; k++) begin
      t = {r, n[SUM_W-1]};
      n = {n[SUM_W-2:0], 1'b0};
      if (t >= divisor) begin
        t    = t - divisor;
        n[0] = 1'b1;
      end
      r = t[REM_W-1:0];
    end
    num_nxt = n;
    rem_nxt = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        active_r <= 1'b1;
        cnt_r    <= DIVCNT_W'(DIV_CYC - 1);
      end else if (active_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      neg_r <= dividend[SUM_W-1];
      num_r <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      rem_r <= '0;
    end else if (active_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(num_r[DATA_W-1:0]) : $signed(num_r[DATA_W-1:0]);

endmodule
`default_nettype wire

// File: rtl/indexed_store_min_max_mean_unit.sv
// Top level: indexed store with bounds-checked access and min/max/mean statistics.
//
// Usage:
//   Input: drive in_item and raise start; the transaction is taken at a clock
//   edge where start is high and busy is low. busy stays high until the
//   result has been presented.
//   Output: out_strobe is high for one cycle with out_result. The receiver
//   cannot hold off a result.
//   Config: cfg_index 0 writes the store length (low 7 bits), 1 writes
//   default_value. cfg_ready is always high; write only while busy is low.
// Timing:
//   After the accepting edge the unit does the access, scans count entries
//   (count = store length capped at 64; the scan state is visited even for
//   count 0), then divides and raises the result strobe. busy drops after the
//   strobe cycle, so a new transaction cannot be accepted before then.
//   The pace is set by the single memory read port, which scans one entry
//   per cycle, and by the divider, which retires two quotient bits per cycle.
// Reset:
//   rst_n (synchronous) clears every entry's valid bit, so the whole store
//   reads as zero at once; the store length returns to 64, default_value to 0.
`default_nettype none
module indexed_store_min_max_mean_unit
  import ismm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire ismm_in_t          in_item,
  output logic                   out_strobe,
  output ismm_out_t              out_result,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [DATA_W-1:0] cfg_data
);

  ismm_state_t state_r, state_nxt;

  logic [CNT_W-1:0]         store_len_r;
  logic signed [DATA_W-1:0] default_value_r;

  // transaction latch
  logic                     op_r;
  logic [AW-1:0]            idx_r;
  logic signed [DATA_W-1:0] val_r;
  logic                     ok_r;
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_w;
  logic                     accept;

  // store
  logic [DATA_W-1:0]        mem [DEPTH];
  logic [DEPTH-1:0]         valid_r;
  logic [DATA_W-1:0]        rdata_r;
  logic                     rvld_r;
  logic [AW-1:0]            mem_addr;
  logic                     mem_we;
  logic signed [DATA_W-1:0] entry;

  // scan
  logic [AW-1:0]            scan_idx_r, scan_idx_nxt;
  logic                     acc_vld_r, acc_vld_nxt;
  logic                     acc_first_r;
  logic                     cap_rd_r;
  logic signed [DATA_W-1:0] rd_r;
  logic signed [DATA_W-1:0] mn_r;
  logic signed [DATA_W-1:0] mx_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [DATA_W-1:0] mean_r;
  logic                     scan_end;

  logic                     div_go;
  logic                     div_done;
  logic signed [DATA_W-1:0] div_q;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign count_w   = (store_len_r > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : store_len_r;
  assign entry     = rvld_r ? $signed(rdata_r) : '0;
  assign scan_end  = (count_r == '0) || ({1'b0, scan_idx_r} == count_r - 1'b1);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_len_r     <= CNT_W'(DEPTH);
      default_value_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STORE_LEN:     store_len_r     <= cfg_data[CNT_W-1:0];
        REG_DEFAULT_VALUE: default_value_r <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    scan_idx_nxt = scan_idx_r;
    acc_vld_nxt  = 1'b0;
    mem_addr     = scan_idx_r;
    mem_we       = 1'b0;
    div_go       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_ACCESS;
      end
      ST_ACCESS: begin
        mem_addr     = idx_r;
        mem_we       = (op_r == OP_WRITE) && ok_r;
        scan_idx_nxt = '0;
        state_nxt    = ST_SCAN;
      end
      ST_SCAN: begin
        acc_vld_nxt  = (count_r != '0);
        scan_idx_nxt = scan_idx_r + 1'b1;
        if (scan_end) state_nxt = ST_LAST;
      end
      ST_LAST: begin
        state_nxt = ST_DIVGO;
      end
      ST_DIVGO: begin
        div_go    = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_idx_r  <= '0;
      acc_vld_r   <= 1'b0;
      acc_first_r <= 1'b0;
      cap_rd_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_idx_r <= scan_idx_nxt;
      acc_vld_r  <= acc_vld_nxt;
      cap_rd_r   <= (state_r == ST_ACCESS);
      if (state_r == ST_ACCESS) begin
        acc_first_r <= 1'b1;
      end else if (acc_vld_r) begin
        acc_first_r <= 1'b0;
      end
    end
  end

  // latch the transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_item.opcode;
      idx_r   <= in_item.index[AW-1:0];
      val_r   <= in_item.value;
      count_r <= count_w;
      ok_r    <= !in_item.index[7] && ({1'b0, in_item.index[6:0]} < 8'(count_w));
    end
  end

  // entry store; valid bits make unwritten entries read as zero after reset
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= val_r;
    rdata_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rvld_r  <= 1'b0;
    end else begin
      rvld_r <= valid_r[mem_addr];
      if (mem_we) valid_r[mem_addr] <= 1'b1;
    end
  end

  // read data of the item arrives in the first scan cycle
  always_ff @(posedge clk) begin
    if (cap_rd_r) begin
      if (op_r == OP_WRITE) begin
        rd_r <= '0;
      end else begin
        rd_r <= ok_r ? entry : default_value_r;
      end
    end
  end

  // running min, max and sum
  always_ff @(posedge clk) begin
    if (acc_vld_r) begin
      if (acc_first_r) begin
        mn_r  <= entry;
        mx_r  <= entry;
        sum_r <= SUM_W'(entry);
      end else begin
        if (entry < mn_r) mn_r <= entry;
        if (entry > mx_r) mx_r <= entry;
        sum_r <= sum_r + SUM_W'(entry);
      end
    end
  end

  ismm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (sum_r),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (div_done) mean_r <= div_q;
  end

  assign out_strobe            = (state_r == ST_DONE);
  assign out_result.read_value = rd_r;
  assign out_result.in_bounds  = ok_r;
  assign out_result.minimum    = (count_r == '0) ? default_value_r : mn_r;
  assign out_result.maximum    = (count_r == '0) ? default_value_r : mx_r;
  assign out_result.mean       = (count_r == '0) ? default_value_r : mean_r;

endmodule
`default_nettype wire
